// ===== src/dlbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_pkg
// Shared types and constants of the baby-step giant-step discrete log core.
// ----------------------------------------------------------------------------
package dlbs_pkg;

    localparam int FIELD_BITS = 12;
    localparam int LOG_BITS   = 13;

    typedef struct packed {
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] modulus;
        logic [FIELD_BITS-1:0] target;
    } t_in;

    typedef struct packed {
        logic [LOG_BITS-1:0] log_value;
        logic                found;
        logic                verified;
    } t_out;

    // Operand selection of the shared modular multiplier; the result goes back
    // to the register that the selection names.
    typedef enum logic [2:0] {
        MS_RED_A  = 3'd0,
        MS_RED_Y  = 3'd1,
        MS_CUR_A  = 3'd2,
        MS_ACC_SQ = 3'd3,
        MS_SQ_SQ  = 3'd4,
        MS_CUR_G  = 3'd5
    } t_mul_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RED_A,
        ST_RED_A_W,
        ST_RED_Y,
        ST_RED_Y_W,
        ST_SQRT,
        ST_CLEAR,
        ST_BABY_INIT,
        ST_BABY_WR,
        ST_BABY_W,
        ST_POW_G_INIT,
        ST_PW_CHK,
        ST_PW_MA,
        ST_PW_MA_W,
        ST_PW_MS,
        ST_PW_MS_W,
        ST_G_TAKE,
        ST_GIANT_MUL,
        ST_GIANT_W,
        ST_GIANT_RD,
        ST_GIANT_CHK,
        ST_POW_V_INIT,
        ST_V_TAKE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     sqrt_step;
        logic     clr_step;
        logic     baby_init;
        logic     baby_write;
        logic     j_inc;
        logic     pow_init_g;
        logic     pow_init_v;
        logic     e_shift;
        logic     g_take;
        logic     giant_init;
        logic     giant_check;
        logic     giant_next;
        logic     v_take;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic p_zero;
        logic mul_done;
        logic sqrt_done;
        logic clr_done;
        logic baby_last;
        logic e_zero;
        logic e_lsb;
        logic hit;
        logic giant_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== src/dlbs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dlbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== src/dlbs_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_mulmod
// Iterative modular multiplier: u * v mod p, one bit of v per cycle, MSB first.
// ----------------------------------------------------------------------------
module dlbs_mulmod #(
    parameter int W = 12
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_u,
    input  wire logic [W-1:0] i_v,
    input  wire logic [W-1:0] i_p,
    output logic              o_done,
    output logic [W-1:0]      o_res
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_acc;
    logic [W-1:0]    r_u;
    logic [W-1:0]    r_v;
    logic [W:0]      dbl;
    logic [W:0]      dbl_red;
    logic [W:0]      sum;
    logic [W:0]      sum_red;

    // The accumulator stays below p, so one subtraction after each of the
    // doubling and the addition keeps it reduced. A u of one with p of one
    // also works out, as the addition is then reduced to zero.
    always_comb begin
        dbl     = {r_acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_p}) ? dbl - {1'b0, i_p} : dbl;
        sum     = dbl_red + (r_v[W-1] ? {1'b0, r_u} : '0);
        sum_red = (sum >= {1'b0, i_p}) ? sum - {1'b0, i_p} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNTW'(W);
            r_acc <= '0;
            r_u   <= i_u;
            r_v   <= i_v;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            r_acc <= sum_red[W-1:0];
            r_v   <= {r_v[W-2:0], 1'b0};
        end
    end

    assign o_res = r_acc;

endmodule
`default_nettype wire

// ===== src/dlbs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_datapath
// Problem registers, square root, baby table, multiplier and result register.
// ----------------------------------------------------------------------------
module dlbs_datapath
    import dlbs_pkg::*;
#(
    parameter int W           = 12,
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int RW  = (W + 1) / 2 + 1;
    localparam int MB  = RW + 1;
    localparam int XW  = 2 * MB;
    localparam int SQW = W + 2;
    localparam int CW  = ((W > AW) ? W : AW) + 1;
    localparam int EW  = MB + 1;

    logic [W-1:0]   r_p, r_a_raw, r_y_raw, r_a, r_y;
    logic [W-1:0]   r_cur, r_acc, r_sq, r_g;
    logic [RW-1:0]  r_r;
    logic [SQW-1:0] r_sqv;
    logic [CW-1:0]  r_clr;
    logic [MB-1:0]  r_j, r_i;
    logic [XW-1:0]  r_im, r_e, r_x;
    logic           r_found, r_verified;
    t_mul_sel       r_dst;
    t_out           r_out;
    logic           r_out_valid;

    logic [MB-1:0]  m;
    logic [W-1:0]   one_p;
    logic [W-1:0]   mul_u, mul_v, mul_res;
    logic           mul_done;
    logic           cur_in_range;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;
    logic           hit;

    assign m     = MB'(r_r) + MB'(1);
    assign one_p = (r_p == W'(1)) ? '0 : W'(1);

    assign cur_in_range = CW'(r_cur) < CW'(TABLE_DEPTH);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_RED_A:  begin mul_u = W'(1); mul_v = r_a_raw; end
            MS_RED_Y:  begin mul_u = W'(1); mul_v = r_y_raw; end
            MS_CUR_A:  begin mul_u = r_cur; mul_v = r_a;     end
            MS_ACC_SQ: begin mul_u = r_acc; mul_v = r_sq;    end
            MS_SQ_SQ:  begin mul_u = r_sq;  mul_v = r_sq;    end
            MS_CUR_G:  begin mul_u = r_cur; mul_v = r_g;     end
            default:   begin mul_u = '0;    mul_v = '0;      end
        endcase
    end

    dlbs_mulmod #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_u     (mul_u),
        .i_v     (mul_v),
        .i_p     (r_p),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // The table is shared by the clearing pass and the baby steps; the giant
    // steps read the entry that the current residue addresses.
    always_comb begin
        ram_we    = i_cmd.clr_step || (i_cmd.baby_write && cur_in_range);
        ram_waddr = i_cmd.clr_step ? AW'(r_clr) : AW'(r_cur);
        ram_wdata = i_cmd.clr_step ? '0 : {1'b1, r_j};
    end

    dlbs_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_cur)),
        .o_rdata (ram_rdata)
    );

    assign hit = cur_in_range && ram_rdata[EW-1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p        <= W'(i_in_data.modulus);
            r_a_raw    <= W'(i_in_data.base);
            r_y_raw    <= W'(i_in_data.target);
            r_r        <= '0;
            r_sqv      <= SQW'(1);
            r_clr      <= '0;
            r_x        <= '0;
            r_found    <= 1'b0;
            r_verified <= 1'b0;
        end
        if (i_cmd.mul_start) begin
            r_dst <= i_cmd.mul_sel;
        end
        if (mul_done) begin
            case (r_dst)
                MS_RED_A:  r_a   <= mul_res;
                MS_RED_Y:  r_y   <= mul_res;
                MS_CUR_A:  r_cur <= mul_res;
                MS_ACC_SQ: r_acc <= mul_res;
                MS_SQ_SQ:  r_sq  <= mul_res;
                MS_CUR_G:  r_cur <= mul_res;
                default:   r_cur <= r_cur;
            endcase
        end
        // (r+2)^2 = (r+1)^2 + 2r + 3
        if (i_cmd.sqrt_step) begin
            r_r   <= r_r + RW'(1);
            r_sqv <= r_sqv + SQW'({r_r, 1'b0}) + SQW'(3);
        end
        if (i_cmd.clr_step) begin
            r_clr <= r_clr + CW'(1);
        end
        if (i_cmd.baby_init) begin
            r_cur <= r_y;
            r_j   <= '0;
        end
        if (i_cmd.j_inc) begin
            r_j <= r_j + MB'(1);
        end
        if (i_cmd.pow_init_g || i_cmd.pow_init_v) begin
            r_acc <= one_p;
            r_sq  <= r_a;
            r_e   <= i_cmd.pow_init_g ? XW'(m) : r_x;
        end
        if (i_cmd.e_shift) begin
            r_e <= r_e >> 1;
        end
        if (i_cmd.g_take) begin
            r_g <= r_acc;
        end
        if (i_cmd.giant_init) begin
            r_cur <= one_p;
            r_i   <= MB'(1);
            r_im  <= XW'(m);
        end
        if (i_cmd.giant_check && hit) begin
            r_x     <= r_im - XW'(ram_rdata[MB-1:0]);
            r_found <= 1'b1;
        end
        if (i_cmd.giant_next) begin
            r_i  <= r_i + MB'(1);
            r_im <= r_im + XW'(m);
        end
        if (i_cmd.v_take) begin
            r_verified <= (r_acc == r_y);
        end
        if (i_cmd.out_load) begin
            r_out.log_value <= LOG_BITS'(r_x);
            r_out.found     <= r_found;
            r_out.verified  <= r_verified;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.p_zero     = (r_p == '0);
        o_sts.mul_done   = mul_done;
        o_sts.sqrt_done  = r_sqv > SQW'(r_p);
        o_sts.clr_done   = (r_clr == CW'(r_p)) || (r_clr == CW'(TABLE_DEPTH));
        o_sts.baby_last  = (r_j + MB'(1)) == m;
        o_sts.e_zero     = (r_e == '0);
        o_sts.e_lsb      = r_e[0];
        o_sts.hit        = hit;
        o_sts.giant_last = (r_i == m);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== src/dlbs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_ctrl
// Sequencer of one problem: reduce, square root, clear, baby, giant, verify.
// ----------------------------------------------------------------------------
module dlbs_ctrl
    import dlbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_verify, n_verify;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_verify <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_verify <= n_verify;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_verify = r_verify;
        case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_CHECK;
            ST_CHECK:      n_state = i_sts.p_zero ? ST_DONE : ST_RED_A;
            ST_RED_A:      n_state = ST_RED_A_W;
            ST_RED_A_W:    if (i_sts.mul_done) n_state = ST_RED_Y;
            ST_RED_Y:      n_state = ST_RED_Y_W;
            ST_RED_Y_W:    if (i_sts.mul_done) n_state = ST_SQRT;
            ST_SQRT:       if (i_sts.sqrt_done) n_state = ST_CLEAR;
            ST_CLEAR:      if (i_sts.clr_done) n_state = ST_BABY_INIT;
            ST_BABY_INIT:  n_state = ST_BABY_WR;
            ST_BABY_WR:    n_state = i_sts.baby_last ? ST_POW_G_INIT : ST_BABY_W;
            ST_BABY_W:     if (i_sts.mul_done) n_state = ST_BABY_WR;
            ST_POW_G_INIT: begin
                n_state  = ST_PW_CHK;
                n_verify = 1'b0;
            end
            ST_PW_CHK: begin
                if (i_sts.e_zero) begin
                    n_state = r_verify ? ST_V_TAKE : ST_G_TAKE;
                end else if (i_sts.e_lsb) begin
                    n_state = ST_PW_MA;
                end else begin
                    n_state = ST_PW_MS;
                end
            end
            ST_PW_MA:      n_state = ST_PW_MA_W;
            ST_PW_MA_W:    if (i_sts.mul_done) n_state = ST_PW_MS;
            ST_PW_MS:      n_state = ST_PW_MS_W;
            ST_PW_MS_W:    if (i_sts.mul_done) n_state = ST_PW_CHK;
            ST_G_TAKE:     n_state = ST_GIANT_MUL;
            ST_GIANT_MUL:  n_state = ST_GIANT_W;
            ST_GIANT_W:    if (i_sts.mul_done) n_state = ST_GIANT_RD;
            ST_GIANT_RD:   n_state = ST_GIANT_CHK;
            ST_GIANT_CHK: begin
                if (i_sts.hit) begin
                    n_state = ST_POW_V_INIT;
                end else if (i_sts.giant_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_GIANT_MUL;
                end
            end
            ST_POW_V_INIT: begin
                n_state  = ST_PW_CHK;
                n_verify = 1'b1;
            end
            ST_V_TAKE:     n_state = ST_DONE;
            ST_DONE:       if (i_sts.out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RED_A: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_RED_A;
            end
            ST_RED_Y: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_RED_Y;
            end
            ST_SQRT:       o_cmd.sqrt_step = !i_sts.sqrt_done;
            ST_CLEAR:      o_cmd.clr_step = !i_sts.clr_done;
            ST_BABY_INIT:  o_cmd.baby_init = 1'b1;
            ST_BABY_WR: begin
                o_cmd.baby_write = 1'b1;
                o_cmd.mul_start  = !i_sts.baby_last;
                o_cmd.j_inc      = !i_sts.baby_last;
                o_cmd.mul_sel    = MS_CUR_A;
            end
            ST_POW_G_INIT: o_cmd.pow_init_g = 1'b1;
            ST_PW_MA: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACC_SQ;
            end
            ST_PW_MS: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_SQ_SQ;
                o_cmd.e_shift   = 1'b1;
            end
            ST_G_TAKE: begin
                o_cmd.g_take     = 1'b1;
                o_cmd.giant_init = 1'b1;
            end
            ST_GIANT_MUL: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_CUR_G;
            end
            ST_GIANT_CHK: begin
                o_cmd.giant_check = 1'b1;
                o_cmd.giant_next  = !i_sts.hit && !i_sts.giant_last;
            end
            ST_POW_V_INIT: o_cmd.pow_init_v = 1'b1;
            ST_V_TAKE:     o_cmd.v_take = 1'b1;
            ST_DONE:       o_cmd.out_load = i_sts.out_free;
            default:       o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/discrete_log_baby_giant_step_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// discrete_log_baby_giant_step_core
// Solves base^x = target mod modulus by baby-step giant-step, one problem at
// a time.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (t_in)
// result    out        o_out_valid / i_out_ready  o_out_data (t_out)
//
// The run time of a problem is set by the bit-serial modular multiplier, shared
// by the reductions, all baby and giant steps and the powers base^m and base^x,
// with m = floor(sqrt(p)) + 1, and by the table clearing pass over
// min(p, TABLE_DEPTH) entries that every problem with a nonzero modulus runs.
// Nothing is cleared after reset itself.
// A new problem is taken while the previous result waits in the output
// register; a stalled output only holds the block at the end of a problem.
// ----------------------------------------------------------------------------
module discrete_log_baby_giant_step_core
    import dlbs_pkg::*;
#(
    parameter int MODULUS_BITS = 12,
    parameter int TABLE_DEPTH  = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    dlbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dlbs_datapath #(
        .W           (MODULUS_BITS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== src/dlbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlbs_checker
// Port-level checks of the discrete log core, bound to the top level.
// ----------------------------------------------------------------------------
module dlbs_checker
    import dlbs_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire t_out i_out_data
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Once a problem is taken the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    a_verified_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_data.verified || i_out_data.found))
        else $error("verified without a match");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.found |-> (i_out_data.log_value == '0))
        else $error("exponent not zero without a match");

endmodule

bind discrete_log_baby_giant_step_core dlbs_checker u_dlbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the baby-step giant-step discrete log core: a directed table of
// problems followed by random ones, each result compared with a behavioural
// solver, with random gaps on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import dlbs_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_out solutions_due[$];
    int   error_count = 0;
    bit   hold_off = 1'b0;
    bit   stimulus_done = 1'b0;

    discrete_log_baby_giant_step_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int mul_mod(int u, int v, int p);
        longint prod;
        prod = longint'(u) * longint'(v);
        return int'(prod % p);
    endfunction

    function automatic int pow_mod(int a, int e, int p);
        int acc;
        int sq;
        acc = 1 % p;
        sq = a % p;
        while (e > 0) begin
            if (e & 1) acc = mul_mod(acc, sq, p);
            sq = mul_mod(sq, sq, p);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Solves one problem the way the core does, with the last baby step
    // written to a residue taking precedence.
    function automatic t_out solve_log(t_in req);
        int   step_at[int];
        int   p, a, y, m, cur, g, x;
        t_out res;
        res = '0;
        p = int'(req.modulus);
        if (p == 0) return res;
        a = int'(req.base) % p;
        y = int'(req.target) % p;
        m = 0;
        while ((m + 1) * (m + 1) <= p) m++;
        m++;
        cur = y;
        for (int j = 0; j < m; j++) begin
            step_at[cur] = j;
            cur = mul_mod(cur, a, p);
        end
        g = pow_mod(a, m, p);
        cur = 1 % p;
        for (int i = 1; i <= m; i++) begin
            cur = mul_mod(cur, g, p);
            if (step_at.exists(cur)) begin
                x = i * m - step_at[cur];
                res.log_value = x[LOG_BITS-1:0];
                res.found = 1'b1;
                res.verified = (pow_mod(a, x, p) == y);
                break;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    // Valid is only dropped when a gap follows, so back-to-back items keep it high.
    task automatic send_problem(t_in req, bit typed, t_out want);
        t_out pred;
        int   gap;
        gap = $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pred = solve_log(req);
        if (typed && pred != want)
            report_mismatch("typed expectation", int'(pred), int'(want));
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        solutions_due.push_back(pred);
    endtask

    // Directed rows: base, modulus, target, whether the answer is typed, answer.
    typedef struct {
        int  b, p, y;
        bit  typed;
        t_out want;
    } t_row;

    t_row rows[] = '{
        '{2, 0, 5, 1, '{13'd0, 1'b0, 1'b0}},
        '{4095, 0, 4095, 1, '{13'd0, 1'b0, 1'b0}},
        '{0, 1, 0, 0, '0},
        '{4095, 1, 4095, 0, '0},
        '{3, 7, 1, 0, '0},
        '{3, 7, 6, 0, '0},
        '{2, 7, 3, 1, '{13'd0, 1'b0, 1'b0}},
        '{0, 13, 0, 0, '0},
        '{0, 13, 5, 0, '0},
        '{1, 13, 1, 0, '0},
        '{1, 13, 2, 0, '0},
        '{5000 % 4096, 4093, 4095, 0, '0},
        '{2, 4093, 4092, 0, '0},
        '{4095, 4095, 0, 0, '0},
        '{4095, 4095, 4094, 0, '0},
        '{2, 2, 1, 0, '0},
        '{3, 2, 3, 0, '0},
        '{2, 4096 - 1, 2048, 0, '0},
        '{2730, 1365, 2730, 0, '0},
        '{1365, 2730, 1365, 0, '0},
        '{7, 4093, 0, 0, '0}
    };

    initial begin : driver
        t_in req;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) begin
            req.base = FIELD_BITS'(rows[k].b);
            req.modulus = FIELD_BITS'(rows[k].p);
            req.target = FIELD_BITS'(rows[k].y);
            send_problem(req, rows[k].typed, rows[k].want);
        end
        i_in_valid <= 1'b0;
        // The sender pauses here until every result has come.
        while (solutions_due.size() != 0) @(posedge i_clk);
        hold_off = 1'b1;
        for (int n = 0; n < 80; n++) begin
            req.base = FIELD_BITS'($urandom_range(0, 4095));
            case ($urandom_range(0, 3))
                0: req.modulus = FIELD_BITS'($urandom_range(0, 4095));
                1: req.modulus = FIELD_BITS'($urandom_range(2, 64));
                default: req.modulus = FIELD_BITS'($urandom_range(2, 600));
            endcase
            req.target = FIELD_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                : (req.modulus != 0 ? pow_mod(int'(req.base), $urandom_range(0, 4095),
                   int'(req.modulus)) : 0));
            send_problem(req, 1'b0, '0);
        end
        i_in_valid <= 1'b0;
        while (solutions_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        stimulus_done = 1'b1;
    end

    initial begin : receiver
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                // Long stall so that the core fills and holds its input.
                i_out_ready <= 1'b0;
                repeat (40000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_cycles = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (solutions_due.size() == 0) begin
                report_mismatch("unexpected transfer", int'(o_out_data), 0);
            end else begin
                want = solutions_due.pop_front();
                if (o_out_data.log_value != want.log_value)
                    report_mismatch("log_value", int'(o_out_data.log_value),
                                    int'(want.log_value));
                if (o_out_data.found != want.found)
                    report_mismatch("found", int'(o_out_data.found), int'(want.found));
                if (o_out_data.verified != want.verified)
                    report_mismatch("verified", int'(o_out_data.verified),
                                    int'(want.verified));
            end
        end
    end

    initial begin : finisher
        wait (stimulus_done);
        if (error_count == 0 && solutions_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/dlbs_pkg.sv
src/dlbs_ram.sv
src/dlbs_mulmod.sv
src/dlbs_datapath.sv
src/dlbs_ctrl.sv
src/discrete_log_baby_giant_step_core.sv
src/dlbs_checker.sv
bench/testbench.sv
